// ===== design/mnbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnbe_pkg
// Shared constants of the mesh normal and bounds engine: command and status
// codes and default store depths.
// ----------------------------------------------------------------------------
package mnbe_pkg;

	localparam int MAX_VERTICES_DEF = 1024;
	localparam int MAX_FACES_DEF    = 2048;

	localparam logic [2:0] CMD_CLEAR        = 3'd0;
	localparam logic [2:0] CMD_LOAD_VERTEX  = 3'd1;
	localparam logic [2:0] CMD_LOAD_FACE    = 3'd2;
	localparam logic [2:0] CMD_FACE_QUERY   = 3'd3;
	localparam logic [2:0] CMD_VERTEX_QUERY = 3'd4;
	localparam logic [2:0] CMD_BOX_QUERY    = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_NO_VERTEX = 2'd2;

endpackage

// ===== design/mnbe_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mnbe_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/mesh_normal_and_bounds_engine_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesh_normal_and_bounds_engine_unit
// Triangle mesh store with face normals, vertex normal sums and a bounding box.
// One shared multiplier, a bit-serial square root and a bit-serial divider
// run under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  input   | in_valid, in_stall | cmd, item_index, coord_x/y/z, corner_a/b/c
//  output  | out_valid,out_stall| status, last, out_x, out_y, out_z
//
// A face load and a vertex normal query run the one-bit normalizing shift
// loop, the 32-step square root and the bit-serial divide per component; a
// degenerate face or a zero vertex normal sum skips all three. Clear sweeps
// the loaded marks over max(MAX_VERTICES, MAX_FACES) addresses; the same
// sweep runs after reset, during which in_stall stays high. in_stall is high
// whenever a transaction is in work; a result held by out_stall does not
// block the next transaction.
// ----------------------------------------------------------------------------
module mesh_normal_and_bounds_engine_unit
	import mnbe_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int MAX_FACES    = MAX_FACES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [10:0]        item_index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [9:0]         corner_a,
	input  logic [9:0]         corner_b,
	input  logic [9:0]         corner_c,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               last,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z
);

	localparam int VA    = MAX_VERTICES > 1 ? $clog2(MAX_VERTICES) : 1;
	localparam int FA    = MAX_FACES > 1 ? $clog2(MAX_FACES) : 1;
	localparam int MAXSW = MAX_VERTICES > MAX_FACES ? MAX_VERTICES : MAX_FACES;
	localparam int SW    = $clog2(MAXSW);

	typedef enum logic [20:0] {
		S_IDLE  = 21'h000001,
		S_SWEEP = 21'h000002,
		S_VLD   = 21'h000004,
		S_FRD   = 21'h000008,
		S_FWT   = 21'h000010,
		S_ESH   = 21'h000020,
		S_CROSS = 21'h000040,
		S_CRL   = 21'h000080,
		S_NSH   = 21'h000100,
		S_SQ    = 21'h000200,
		S_SQRT  = 21'h000400,
		S_DIV   = 21'h000800,
		S_NEND  = 21'h001000,
		S_FWR   = 21'h002000,
		S_SRD   = 21'h004000,
		S_SWR   = 21'h008000,
		S_QRD   = 21'h010000,
		S_QWT   = 21'h020000,
		S_VRD   = 21'h040000,
		S_VWT   = 21'h080000,
		S_EMIT  = 21'h100000
	} state_t;

	state_t state_q;

	logic [2:0]         cmd_q;
	logic [10:0]        idx_q;
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [9:0]         ca_q, cb_q, cc_q;
	logic [1:0]         k_q;
	logic [5:0]         cnt_q;
	logic [SW-1:0]      sweep_q;
	logic               clr_emit_q;

	logic signed [31:0] a_q [3];
	logic signed [32:0] e_q [6];
	logic signed [30:0] es_q [6];
	logic signed [61:0] cr_q [3];
	logic               nsgn_q [3];
	logic [61:0]        nmag_q [3];
	logic signed [63:0] prod_q;
	logic [63:0]        ss_q, rem_q, res_q, bit_q;
	logic [45:0]        drem_q, dsh_q;
	logic [14:0]        quo_q;
	logic signed [15:0] n_q [3];

	logic               box_valid_q;
	logic signed [31:0] box_min_q [3];
	logic signed [31:0] box_max_q [3];

	logic [1:0]         res_status_q;
	logic               res_last_q;
	logic signed [31:0] res_x_q, res_y_q, res_z_q;

	logic               out_valid_q, last_q;
	logic [1:0]         status_q;
	logic signed [31:0] out_x_q, out_y_q, out_z_q;

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign last      = last_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;
	assign in_stall  = (state_q != S_IDLE);

	function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
			input logic signed [15:0] b);
		logic signed [32:0] r;
		r = 33'(a) + 33'(b);
		if (r[32] != r[31]) begin
			return r[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
		end
		return r[31:0];
	endfunction

	// index decode
	logic        in_acc;
	logic        v_ok, f_ok, c_ok;
	logic [31:0] idx32, corner32;
	logic [9:0]  corner_sel;
	logic [VA-1:0] idx_vaddr, corner_vaddr;
	logic [FA-1:0] idx_faddr;

	assign in_acc = in_valid && !in_stall;
	assign v_ok   = 32'(item_index) < 32'(MAX_VERTICES);
	assign f_ok   = 32'(item_index) < 32'(MAX_FACES);
	assign c_ok   = (32'(corner_a) < 32'(MAX_VERTICES)) && (32'(corner_b) < 32'(MAX_VERTICES))
		&& (32'(corner_c) < 32'(MAX_VERTICES));
	assign idx32  = 32'(idx_q);
	assign corner_sel = (k_q == 2'd0) ? ca_q : ((k_q == 2'd1) ? cb_q : cc_q);
	assign corner32   = 32'(corner_sel);
	assign idx_vaddr    = idx32[VA-1:0];
	assign corner_vaddr = corner32[VA-1:0];
	assign idx_faddr    = idx32[FA-1:0];

	// memories
	logic          pos_we, sum_we, face_we;
	logic [VA-1:0] pos_waddr, sum_waddr, vraddr;
	logic [FA-1:0] face_waddr;
	logic [96:0]   pos_wdata, pos_rd;
	logic [95:0]   sum_wdata, sum_rd;
	logic [48:0]   face_wdata, face_rd;
	logic          sweep_v, sweep_f;

	assign sweep_v = 32'(sweep_q) < 32'(MAX_VERTICES);
	assign sweep_f = 32'(sweep_q) < 32'(MAX_FACES);
	assign vraddr  = (state_q == S_VRD) ? idx_vaddr : corner_vaddr;

	assign pos_we    = ((state_q == S_SWEEP) && sweep_v) || (state_q == S_VLD);
	assign pos_waddr = (state_q == S_SWEEP) ? sweep_q[VA-1:0] : idx_vaddr;
	assign pos_wdata = (state_q == S_SWEEP) ? '0 : {1'b1, cx_q, cy_q, cz_q};

	assign sum_we    = (state_q == S_VLD) || (state_q == S_SWR);
	assign sum_waddr = (state_q == S_VLD) ? idx_vaddr : corner_vaddr;
	assign sum_wdata = (state_q == S_VLD) ? '0 :
		{sat_add(sum_rd[95:64], n_q[0]), sat_add(sum_rd[63:32], n_q[1]),
		 sat_add(sum_rd[31:0], n_q[2])};

	assign face_we    = ((state_q == S_SWEEP) && sweep_f) || (state_q == S_FWR);
	assign face_waddr = (state_q == S_SWEEP) ? sweep_q[FA-1:0] : idx_faddr;
	assign face_wdata = (state_q == S_SWEEP) ? '0 : {1'b1, n_q[0], n_q[1], n_q[2]};

	mnbe_ram #(.WIDTH(97), .DEPTH(MAX_VERTICES)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(vraddr), .rdata(pos_rd)
	);

	mnbe_ram #(.WIDTH(96), .DEPTH(MAX_VERTICES)) u_sum (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(vraddr), .rdata(sum_rd)
	);

	mnbe_ram #(.WIDTH(49), .DEPTH(MAX_FACES)) u_face (
		.clk(clk), .we(face_we), .waddr(face_waddr), .wdata(face_wdata),
		.raddr(idx_faddr), .rdata(face_rd)
	);

	// shared multiplier
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_CROSS) begin
			case (cnt_q)
				6'd0: begin mul_a = 32'(es_q[1]); mul_b = 32'(es_q[5]); end
				6'd1: begin mul_a = 32'(es_q[2]); mul_b = 32'(es_q[4]); end
				6'd2: begin mul_a = 32'(es_q[2]); mul_b = 32'(es_q[3]); end
				6'd3: begin mul_a = 32'(es_q[0]); mul_b = 32'(es_q[5]); end
				6'd4: begin mul_a = 32'(es_q[0]); mul_b = 32'(es_q[4]); end
				6'd5: begin mul_a = 32'(es_q[1]); mul_b = 32'(es_q[3]); end
				default: ;
			endcase
		end else if (state_q == S_SQ && cnt_q < 6'd3) begin
			mul_a = {1'b0, nmag_q[cnt_q[1:0]][30:0]};
			mul_b = {1'b0, nmag_q[cnt_q[1:0]][30:0]};
		end
	end

	assign mul_p = mul_a * mul_b;

	// edge scaling
	logic [32:0] emag [6];
	logic [32:0] eorr;
	logic [1:0]  esh;
	logic [29:0] em30 [6];

	always_comb begin
		eorr = '0;
		for (int i = 0; i < 6; i++) begin
			emag[i] = e_q[i][32] ? 33'(-e_q[i]) : 33'(e_q[i]);
			eorr    = eorr | emag[i];
		end
		esh = eorr[32] ? 2'd3 : (eorr[31] ? 2'd2 : (eorr[30] ? 2'd1 : 2'd0));
		for (int i = 0; i < 6; i++) begin
			em30[i] = 30'(emag[i] >> esh);
		end
	end

	// normalize helpers
	logic [61:0] norr;
	logic [63:0] sq_t;
	logic        sq_ge, dv_ge;
	logic [14:0] qn;
	logic [31:0] len;
	logic [31:0] smag [3];

	assign norr  = nmag_q[0] | nmag_q[1] | nmag_q[2];
	assign sq_t  = res_q + bit_q;
	assign sq_ge = rem_q >= sq_t;
	assign dv_ge = drem_q >= dsh_q;
	assign qn    = {quo_q[13:0], dv_ge};
	assign len   = res_q[31:0];

	always_comb begin
		smag[0] = sum_rd[95] ? 32'd0 - sum_rd[95:64] : sum_rd[95:64];
		smag[1] = sum_rd[63] ? 32'd0 - sum_rd[63:32] : sum_rd[63:32];
		smag[2] = sum_rd[31] ? 32'd0 - sum_rd[31:0] : sum_rd[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_SWEEP;
			cmd_q        <= '0;
			idx_q        <= '0;
			cx_q         <= '0;
			cy_q         <= '0;
			cz_q         <= '0;
			ca_q         <= '0;
			cb_q         <= '0;
			cc_q         <= '0;
			k_q          <= '0;
			cnt_q        <= '0;
			sweep_q      <= '0;
			clr_emit_q   <= 1'b0;
			prod_q       <= '0;
			ss_q         <= '0;
			rem_q        <= '0;
			res_q        <= '0;
			bit_q        <= '0;
			drem_q       <= '0;
			dsh_q        <= '0;
			quo_q        <= '0;
			box_valid_q  <= 1'b0;
			res_status_q <= ST_OK;
			res_last_q   <= 1'b0;
			res_x_q      <= '0;
			res_y_q      <= '0;
			res_z_q      <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= ST_OK;
			last_q       <= 1'b0;
			out_x_q      <= '0;
			out_y_q      <= '0;
			out_z_q      <= '0;
			for (int i = 0; i < 3; i++) begin
				a_q[i]       <= '0;
				cr_q[i]      <= '0;
				nsgn_q[i]    <= 1'b0;
				nmag_q[i]    <= '0;
				n_q[i]       <= '0;
				box_min_q[i] <= '0;
				box_max_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				e_q[i]  <= '0;
				es_q[i] <= '0;
			end
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cmd_q <= cmd;
						idx_q <= item_index;
						cx_q  <= coord_x;
						cy_q  <= coord_y;
						cz_q  <= coord_z;
						ca_q  <= corner_a;
						cb_q  <= corner_b;
						cc_q  <= corner_c;
						k_q   <= '0;
						res_status_q <= ST_BAD_INDEX;
						res_last_q   <= 1'b1;
						res_x_q      <= '0;
						res_y_q      <= '0;
						res_z_q      <= '0;
						case (cmd)
							CMD_CLEAR: begin
								sweep_q     <= '0;
								clr_emit_q  <= 1'b1;
								box_valid_q <= 1'b0;
								for (int i = 0; i < 3; i++) begin
									box_min_q[i] <= '0;
									box_max_q[i] <= '0;
								end
								state_q <= S_SWEEP;
							end
							CMD_LOAD_VERTEX: state_q <= v_ok ? S_VLD : S_EMIT;
							CMD_LOAD_FACE:   state_q <= (f_ok && c_ok) ? S_FRD : S_EMIT;
							CMD_FACE_QUERY:  state_q <= f_ok ? S_QRD : S_EMIT;
							CMD_VERTEX_QUERY: state_q <= v_ok ? S_VRD : S_EMIT;
							CMD_BOX_QUERY: begin
								if (box_valid_q) begin
									res_status_q <= ST_OK;
									res_last_q   <= 1'b0;
									res_x_q      <= box_min_q[0];
									res_y_q      <= box_min_q[1];
									res_z_q      <= box_min_q[2];
								end else begin
									res_status_q <= ST_NO_VERTEX;
								end
								state_q <= S_EMIT;
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					if (sweep_q == SW'(MAXSW - 1)) begin
						sweep_q      <= '0;
						clr_emit_q   <= 1'b0;
						res_status_q <= ST_OK;
						res_last_q   <= 1'b1;
						res_x_q      <= '0;
						res_y_q      <= '0;
						res_z_q      <= '0;
						state_q      <= clr_emit_q ? S_EMIT : S_IDLE;
					end else begin
						sweep_q <= sweep_q + 1'b1;
					end
				end
				S_VLD: begin
					if (!box_valid_q || cx_q < box_min_q[0]) box_min_q[0] <= cx_q;
					if (!box_valid_q || cy_q < box_min_q[1]) box_min_q[1] <= cy_q;
					if (!box_valid_q || cz_q < box_min_q[2]) box_min_q[2] <= cz_q;
					if (!box_valid_q || cx_q > box_max_q[0]) box_max_q[0] <= cx_q;
					if (!box_valid_q || cy_q > box_max_q[1]) box_max_q[1] <= cy_q;
					if (!box_valid_q || cz_q > box_max_q[2]) box_max_q[2] <= cz_q;
					box_valid_q  <= 1'b1;
					res_status_q <= ST_OK;
					state_q      <= S_EMIT;
				end
				S_FRD: state_q <= S_FWT;
				S_FWT: begin
					if (!pos_rd[96]) begin
						state_q <= S_EMIT;
					end else begin
						unique case (k_q)
							2'd0: begin
								a_q[0] <= pos_rd[95:64];
								a_q[1] <= pos_rd[63:32];
								a_q[2] <= pos_rd[31:0];
							end
							2'd1: begin
								e_q[0] <= 33'(signed'(pos_rd[95:64])) - 33'(a_q[0]);
								e_q[1] <= 33'(signed'(pos_rd[63:32])) - 33'(a_q[1]);
								e_q[2] <= 33'(signed'(pos_rd[31:0])) - 33'(a_q[2]);
							end
							default: begin
								e_q[3] <= 33'(signed'(pos_rd[95:64])) - 33'(a_q[0]);
								e_q[4] <= 33'(signed'(pos_rd[63:32])) - 33'(a_q[1]);
								e_q[5] <= 33'(signed'(pos_rd[31:0])) - 33'(a_q[2]);
							end
						endcase
						if (k_q == 2'd2) begin
							state_q <= S_ESH;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= S_FRD;
						end
					end
				end
				S_ESH: begin
					for (int i = 0; i < 6; i++) begin
						es_q[i] <= e_q[i][32] ? -$signed({1'b0, em30[i]})
							: $signed({1'b0, em30[i]});
					end
					cnt_q   <= '0;
					state_q <= S_CROSS;
				end
				S_CROSS: begin
					prod_q <= mul_p;
					case (cnt_q)
						6'd1: cr_q[0] <= 62'(prod_q);
						6'd2: cr_q[0] <= cr_q[0] - 62'(prod_q);
						6'd3: cr_q[1] <= 62'(prod_q);
						6'd4: cr_q[1] <= cr_q[1] - 62'(prod_q);
						6'd5: cr_q[2] <= 62'(prod_q);
						6'd6: cr_q[2] <= cr_q[2] - 62'(prod_q);
						default: ;
					endcase
					if (cnt_q == 6'd6) begin
						state_q <= S_CRL;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_CRL: begin
					for (int i = 0; i < 3; i++) begin
						nsgn_q[i] <= cr_q[i][61];
						nmag_q[i] <= cr_q[i][61] ? 62'(-cr_q[i]) : 62'(cr_q[i]);
					end
					state_q <= S_NSH;
				end
				S_NSH: begin
					if (norr == '0) begin
						for (int i = 0; i < 3; i++) n_q[i] <= '0;
						state_q <= S_NEND;
					end else if (norr[61:31] != '0) begin
						for (int i = 0; i < 3; i++) nmag_q[i] <= nmag_q[i] >> 1;
					end else if (!norr[30]) begin
						for (int i = 0; i < 3; i++) nmag_q[i] <= nmag_q[i] << 1;
					end else begin
						cnt_q   <= '0;
						ss_q    <= '0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					prod_q <= mul_p;
					if (cnt_q != 6'd0) begin
						ss_q <= ss_q + 64'(prod_q);
					end
					if (cnt_q == 6'd3) begin
						rem_q   <= ss_q + 64'(prod_q);
						res_q   <= '0;
						bit_q   <= 64'd1 << 62;
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_SQRT: begin
					if (sq_ge) begin
						rem_q <= rem_q - sq_t;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (cnt_q == 6'd31) begin
						cnt_q   <= '0;
						k_q     <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						drem_q <= 46'({nmag_q[k_q][30:0], 14'd0}) + 46'(len[31:1]);
						dsh_q  <= {len, 14'd0};
						quo_q  <= '0;
						cnt_q  <= 6'd1;
					end else begin
						if (dv_ge) drem_q <= drem_q - dsh_q;
						quo_q <= qn;
						dsh_q <= dsh_q >> 1;
						if (cnt_q == 6'd15) begin
							n_q[k_q] <= nsgn_q[k_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
							cnt_q    <= '0;
							if (k_q == 2'd2) begin
								state_q <= S_NEND;
							end else begin
								k_q <= k_q + 2'd1;
							end
						end else begin
							cnt_q <= cnt_q + 6'd1;
						end
					end
				end
				S_NEND: begin
					res_status_q <= ST_OK;
					res_x_q      <= 32'(n_q[0]);
					res_y_q      <= 32'(n_q[1]);
					res_z_q      <= 32'(n_q[2]);
					state_q      <= (cmd_q == CMD_LOAD_FACE) ? S_FWR : S_EMIT;
				end
				S_FWR: begin
					k_q     <= '0;
					state_q <= S_SRD;
				end
				S_SRD: state_q <= S_SWR;
				S_SWR: begin
					if (k_q == 2'd2) begin
						state_q <= S_EMIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_SRD;
					end
				end
				S_QRD: state_q <= S_QWT;
				S_QWT: begin
					if (face_rd[48]) begin
						res_status_q <= ST_OK;
						res_x_q      <= 32'(signed'(face_rd[47:32]));
						res_y_q      <= 32'(signed'(face_rd[31:16]));
						res_z_q      <= 32'(signed'(face_rd[15:0]));
					end
					state_q <= S_EMIT;
				end
				S_VRD: state_q <= S_VWT;
				S_VWT: begin
					if (!pos_rd[96]) begin
						state_q <= S_EMIT;
					end else begin
						nsgn_q[0] <= sum_rd[95];
						nsgn_q[1] <= sum_rd[63];
						nsgn_q[2] <= sum_rd[31];
						nmag_q[0] <= 62'(smag[0]);
						nmag_q[1] <= 62'(smag[1]);
						nmag_q[2] <= 62'(smag[2]);
						state_q   <= S_NSH;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						status_q    <= res_status_q;
						last_q      <= res_last_q;
						out_x_q     <= res_x_q;
						out_y_q     <= res_y_q;
						out_z_q     <= res_z_q;
						if (res_last_q) begin
							state_q <= S_IDLE;
						end else begin
							res_last_q <= 1'b1;
							res_x_q    <= box_max_q[0];
							res_y_q    <= box_max_q[1];
							res_z_q    <= box_max_q[2];
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mnbe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mnbe_checker
// Port-level checks of the mesh normal and bounds engine, bound to the top.
// ----------------------------------------------------------------------------
module mnbe_checker
	import mnbe_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [2:0]         cmd,
	input logic               out_valid,
	input logic               out_stall,
	input logic [1:0]         status,
	input logic               last,
	input logic signed [31:0] out_x,
	input logic signed [31:0] out_y,
	input logic signed [31:0] out_z
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(last)
			&& $stable(out_x) && $stable(out_y) && $stable(out_z))
		else $error("stalled result transaction changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd <= CMD_BOX_QUERY |=> in_stall)
		else $error("input not stalled while transaction in work");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> last)
		else $error("error result not marked last");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_x == 0 && out_y == 0 && out_z == 0)
		else $error("error result carries data");

	a_box_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last && !out_stall |=> out_valid && last)
		else $error("box maximum did not follow minimum");

endmodule

bind mesh_normal_and_bounds_engine_unit mnbe_checker u_mnbe_checker (.*);
